// File: rtl/frm_pkg.sv
package frm_pkg;

	localparam int STAMP_W   = 48;
	localparam int FRAC_W    = 16;
	localparam int RATE_W    = 32;
	localparam int FREQ_W    = 32;
	localparam int WINDOW    = 30;
	localparam int PTR_W     = ($clog2(WINDOW) > 0) ? $clog2(WINDOW) : 1;
	localparam int CNT_W     = $clog2(WINDOW + 1);
	localparam int SUM_W     = RATE_W + PTR_W;
	localparam int MS_PER_S  = 1000;
	localparam int MS_W      = 10;
	localparam int MUL_W     = STAMP_W + MS_W;
	localparam int DIV_W     = 64;
	localparam int DEN_W     = STAMP_W;
	localparam int WIDE_W    = (MUL_W > DIV_W) ? MUL_W : DIV_W;
	localparam int SAT_SH    = RATE_W - FRAC_W;
	localparam int Q_DEPTH   = 2;
	localparam int QP_W      = ($clog2(Q_DEPTH) > 0) ? $clog2(Q_DEPTH) : 1;
	localparam int QC_W      = $clog2(Q_DEPTH + 1);
	localparam int IN_DATA_W = ((STAMP_W + 7) / 8) * 8;
	localparam int OUT_RAW_W = 3 * RATE_W + CNT_W;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
	localparam int OUT_USER_W = 2;

	localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(10000000);
	localparam logic [RATE_W-1:0] RATE_SAT   = '1;

	// One classified frame stamp, handed from the front to the back.
	typedef struct packed {
		logic               first;
		logic               zero;
		logic [STAMP_W-1:0] delta;
	} entry_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_CLASS,
		BK_FPS,
		BK_MUL,
		BK_MSCHK,
		BK_MS,
		BK_RDOLD,
		BK_UPD,
		BK_AVG,
		BK_AVGW,
		BK_OUT
	} back_state_t;

endpackage

// File: rtl/frame_rate_meter_top.sv
// Frame rate meter. Send one beat on the s_axis channel per frame start,
// carrying the free-running counter value sampled at that moment. Every
// input beat yields exactly one m_axis beat, in order. The first beat after
// reset only records its stamp and returns a result with valid_res low.
// Later beats return the instantaneous rate, the frame time in ms and the
// mean rate over the last 30 frames, all unsigned 16.16.
// The back end works on one stamp at a time with a single radix-2 divider,
// used in turn for the rate, frame time and average divisions. A first stamp
// skips all three; a zero delta or zero frequency skips the rate and frame
// time divisions, and a saturating frame time skips the frame time division.
// The back end takes the next queued stamp once its result is registered;
// while it works, the queue accepts further stamps until it is full.
// A two-beat queue sits between the front end that takes stamps and the
// back end. A stalled receiver holds the output register; the back end then
// holds one more stamp and the queue two, so three further beats are
// accepted before s_axis_tready drops.
// Reset clears the started flag, the stored stamp, the window and the
// counter frequency (back to 10 MHz). Write cfg_data only while idle.
module frame_rate_meter_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// Counter frequency register, ticks per second.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [frm_pkg::FREQ_W-1:0]     cfg_data,
	// Input stream.
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [47:0] timestamp
	input  logic [frm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// Output stream.
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [31:0] fps, [63:32] avg_fps, [95:64] ms_per_frame, [100:96] window_fill
	output logic [frm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// [0] valid_res, [1] zero_delta
	output logic [frm_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import frm_pkg::*;

	logic [FREQ_W-1:0] freq_q;
	logic              q_full;
	logic              q_push;
	entry_t            q_wr_entry;
	logic              q_valid;
	logic              q_pop;
	entry_t            q_head;

	// The register is always ready; a beat simply overwrites the frequency.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= FREQ_RESET;
		end else if (cfg_valid && cfg_ready) begin
			freq_q <= cfg_data;
		end
	end

	// Front end: computes the tick delta against the previous stamp and
	// marks first and zero-delta frames.
	frm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_entry       (q_wr_entry)
	);

	frm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr_entry),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_entry (q_head)
	);

	// Back end: divisions, window update and the output register.
	frm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.freq          (freq_q),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// File: rtl/frm_div.sv
module frm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [frm_pkg::DIV_W-1:0]  num,
	input  logic [frm_pkg::DEN_W-1:0]  den,
	output logic                       done,
	output logic [frm_pkg::DIV_W-1:0]  quot
);
	import frm_pkg::*;

	localparam int STEP_W = $clog2(DIV_W + 1);

	logic [STEP_W-1:0] step_q;
	logic              done_q;
	logic [DIV_W-1:0]  work_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W:0]    trial;
	logic              ge;
	logic [DEN_W-1:0]  rem_d;

	// Restoring division, one quotient bit per cycle. The dividend shifts out
	// of work_q at the top while quotient bits shift in at the bottom.
	assign trial = {rem_q, work_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign rem_d = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			step_q <= STEP_W'(DIV_W);
			done_q <= 1'b0;
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
			done_q <= (step_q == STEP_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (step_q != '0) begin
			work_q <= {work_q[DIV_W-2:0], ge};
			rem_q  <= rem_d;
		end
	end

	assign done = done_q;
	assign quot = work_q;

endmodule

// File: rtl/frm_front.sv
module frm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [frm_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input  logic                          q_full,
	output logic                          q_push,
	output frm_pkg::entry_t               q_entry
);
	import frm_pkg::*;

	logic               started_q;
	logic [STAMP_W-1:0] last_stamp_q;
	logic [STAMP_W-1:0] stamp;
	logic [STAMP_W-1:0] delta;

	assign stamp         = s_axis_tdata[STAMP_W-1:0];
	assign delta         = stamp - last_stamp_q;
	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && s_axis_tready;

	assign q_entry.first = !started_q;
	assign q_entry.zero  = (delta == '0);
	assign q_entry.delta = delta;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			last_stamp_q <= '0;
		end else if (q_push) begin
			started_q    <= 1'b1;
			last_stamp_q <= stamp;
		end
	end

endmodule

// File: rtl/frm_queue.sv
module frm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  frm_pkg::entry_t wr_entry,
	output logic            full,
	input  logic            pop,
	output logic            rd_valid,
	output frm_pkg::entry_t rd_entry
);
	import frm_pkg::*;

	entry_t          mem_q [Q_DEPTH];
	logic [QP_W-1:0] wptr_q;
	logic [QP_W-1:0] rptr_q;
	logic [QC_W-1:0] fill_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (fill_q == QC_W'(Q_DEPTH));
	assign rd_valid = (fill_q != '0);
	assign rd_entry = mem_q[rptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == QP_W'(Q_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == QP_W'(Q_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wr_entry;
		end
	end

endmodule

// File: rtl/frm_back.sv
module frm_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [frm_pkg::FREQ_W-1:0]     freq,
	input  logic                           q_valid,
	input  frm_pkg::entry_t                q_head,
	output logic                           q_pop,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [frm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic [frm_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import frm_pkg::*;

	back_state_t       state_q;
	back_state_t       state_d;
	entry_t            ent_q;
	logic [RATE_W-1:0] fps_q;
	logic [RATE_W-1:0] ms_q;
	logic [RATE_W-1:0] avg_q;
	logic [RATE_W-1:0] old_q;
	logic [MUL_W-1:0]  m_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [RATE_W-1:0] hist_q [WINDOW];
	logic              win_full;
	logic              ms_sat;
	logic              out_free;

	logic              out_valid_q;
	logic              out_res_q;
	logic              out_zero_q;
	logic [RATE_W-1:0] out_fps_q;
	logic [RATE_W-1:0] out_avg_q;
	logic [RATE_W-1:0] out_ms_q;
	logic [CNT_W-1:0]  out_fill_q;

	logic              div_start;
	logic [DIV_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic              div_done;
	logic [DIV_W-1:0]  div_quot;

	frm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign win_full = (cnt_q == CNT_W'(WINDOW));
	assign out_free = !out_valid_q || m_axis_tready;
	// The frame time overflows exactly when delta * 1000 reaches freq scaled
	// up by the integer bits of the result.
	assign ms_sat   = WIDE_W'(m_q) >= (WIDE_W'(freq) << SAT_SH);

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = BK_CLASS;
				end
			end
			BK_CLASS: begin
				if (ent_q.first) begin
					state_d = BK_OUT;
				end else if (ent_q.zero || freq == '0) begin
					state_d = BK_RDOLD;
				end else begin
					div_start = 1'b1;
					div_num   = DIV_W'(freq) << FRAC_W;
					div_den   = ent_q.delta;
					state_d   = BK_FPS;
				end
			end
			BK_FPS: begin
				if (div_done) begin
					state_d = BK_MUL;
				end
			end
			BK_MUL: begin
				state_d = BK_MSCHK;
			end
			BK_MSCHK: begin
				if (ms_sat) begin
					state_d = BK_RDOLD;
				end else begin
					div_start = 1'b1;
					div_num   = DIV_W'(WIDE_W'(m_q) << FRAC_W);
					div_den   = DEN_W'(freq);
					state_d   = BK_MS;
				end
			end
			BK_MS: begin
				if (div_done) begin
					state_d = BK_RDOLD;
				end
			end
			BK_RDOLD: begin
				state_d = BK_UPD;
			end
			BK_UPD: begin
				state_d = BK_AVG;
			end
			BK_AVG: begin
				div_start = 1'b1;
				div_num   = DIV_W'(sum_q);
				div_den   = DEN_W'(cnt_q);
				state_d   = BK_AVGW;
			end
			BK_AVGW: begin
				if (div_done) begin
					state_d = BK_OUT;
				end
			end
			BK_OUT: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Window bookkeeping: the oldest rate leaves the sum once the window is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			ptr_q <= '0;
		end else if (state_q == BK_UPD) begin
			sum_q <= sum_q - (win_full ? SUM_W'(old_q) : '0) + SUM_W'(fps_q);
			if (!win_full) begin
				cnt_q <= cnt_q + 1'b1;
			end
			ptr_q <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_UPD) begin
			hist_q[ptr_q] <= fps_q;
		end
		if (state_q == BK_RDOLD) begin
			old_q <= hist_q[ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_head;
		end
		case (state_q)
			BK_CLASS: begin
				fps_q <= ent_q.zero ? RATE_SAT : '0;
				ms_q  <= '0;
			end
			BK_FPS: begin
				if (div_done) begin
					fps_q <= (|div_quot[DIV_W-1:RATE_W]) ? RATE_SAT : div_quot[RATE_W-1:0];
				end
			end
			BK_MUL: begin
				m_q <= MUL_W'(ent_q.delta) * MUL_W'(MS_PER_S);
			end
			BK_MSCHK: begin
				if (ms_sat) begin
					ms_q <= RATE_SAT;
				end
			end
			BK_MS: begin
				if (div_done) begin
					ms_q <= div_quot[RATE_W-1:0];
				end
			end
			BK_AVGW: begin
				if (div_done) begin
					avg_q <= div_quot[RATE_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == BK_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_OUT && out_free) begin
			out_res_q  <= !ent_q.first;
			out_zero_q <= !ent_q.first && ent_q.zero;
			out_fps_q  <= ent_q.first ? '0 : fps_q;
			out_avg_q  <= ent_q.first ? '0 : avg_q;
			out_ms_q   <= ent_q.first ? '0 : ms_q;
			out_fill_q <= cnt_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'({out_fill_q, out_ms_q, out_avg_q, out_fps_q});
	assign m_axis_tuser  = {out_zero_q, out_res_q};

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(WINDOW))
		else $error("window count above window size");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q < PTR_W'(WINDOW))
		else $error("history pointer out of range");

	a_cnt_update: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != BK_UPD |=> $stable(cnt_q))
		else $error("window count moved outside the update step");

	a_first_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_res_q |-> out_fps_q == '0 && out_ms_q == '0 && !out_zero_q)
		else $error("first-stamp result carries rate data");

endmodule

// File: tb/frame_rate_meter_checker.sv
module frame_rate_meter_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [frm_pkg::FREQ_W-1:0]     cfg_data,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [frm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [frm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic [frm_pkg::OUT_USER_W-1:0] m_axis_tuser,
	output int                             errors,
	output int                             pending
);
	import frm_pkg::*;

	typedef struct packed {
		logic              valid_res;
		logic              zero_delta;
		logic [CNT_W-1:0]  fill;
		logic [RATE_W-1:0] fps;
		logic [RATE_W-1:0] avg_fps;
		logic [RATE_W-1:0] ms;
	} frame_stats_t;

	logic [FREQ_W-1:0]  tick_freq;
	logic [STAMP_W-1:0] prev_stamp;
	logic               seen_first;
	logic [RATE_W-1:0]  rate_window [WINDOW];
	int unsigned        slot;
	int unsigned        fill;
	logic [63:0]        window_sum;
	frame_stats_t       stats_q [$];

	function automatic logic [RATE_W-1:0] rate_for(logic [STAMP_W-1:0] delta);
		logic [63:0] q;
		if (tick_freq == '0)
			return '0;
		q = (64'(tick_freq) << FRAC_W) / 64'(delta);
		return (q > 64'(RATE_SAT)) ? RATE_SAT : q[RATE_W-1:0];
	endfunction

	function automatic logic [RATE_W-1:0] frame_ms_for(logic [STAMP_W-1:0] delta);
		logic [127:0] prod;
		logic [127:0] q;
		if (tick_freq == '0)
			return '0;
		prod = 128'(delta) * (128'(MS_PER_S) << FRAC_W);
		// The quotient fits in 32 bits only below freq * 2^32.
		if (prod >= (128'(tick_freq) << 32))
			return RATE_SAT;
		q = prod / 128'(tick_freq);
		return q[RATE_W-1:0];
	endfunction

	// Advances the meter state by one stamp and returns the statistics it yields.
	function automatic frame_stats_t measure_frame(logic [STAMP_W-1:0] stamp);
		frame_stats_t       r;
		logic [STAMP_W-1:0] delta;
		r = '0;
		if (!seen_first) begin
			seen_first = 1'b1;
			prev_stamp = stamp;
			r.fill = CNT_W'(fill);
			return r;
		end
		delta = stamp - prev_stamp;
		prev_stamp = stamp;
		r.valid_res = 1'b1;
		if (delta == '0) begin
			r.zero_delta = 1'b1;
			r.fps = RATE_SAT;
			r.ms = '0;
		end else begin
			r.fps = rate_for(delta);
			r.ms = frame_ms_for(delta);
		end
		if (fill < WINDOW)
			fill++;
		else
			window_sum -= 64'(rate_window[slot]);
		rate_window[slot] = r.fps;
		window_sum += 64'(r.fps);
		slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
		r.avg_fps = RATE_W'(window_sum / 64'(fill));
		r.fill = CNT_W'(fill);
		return r;
	endfunction

	task automatic compare_field(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_stats_t want;
		if (!arst_n) begin
			errors = 0;
			tick_freq = FREQ_RESET;
			prev_stamp = '0;
			seen_first = 1'b0;
			for (int i = 0; i < WINDOW; i++)
				rate_window[i] = '0;
			slot = 0;
			fill = 0;
			window_sum = '0;
			stats_q.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				tick_freq = cfg_data;
			// Results leave before a new stamp is queued, so a result that has
			// no stamp in front of it is never matched to one taken at this edge.
			if (m_axis_tvalid && m_axis_tready) begin
				if (stats_q.size() == 0) begin
					$display("%0t: result beat with none expected, got data %h user %h",
						$time, m_axis_tdata, m_axis_tuser);
					errors++;
				end else begin
					want = stats_q.pop_front();
					compare_field("valid_res", 32'(want.valid_res), 32'(m_axis_tuser[0]));
					compare_field("zero_delta", 32'(want.zero_delta), 32'(m_axis_tuser[1]));
					compare_field("fps", want.fps, m_axis_tdata[31:0]);
					compare_field("avg_fps", want.avg_fps, m_axis_tdata[63:32]);
					compare_field("ms_per_frame", want.ms, m_axis_tdata[95:64]);
					compare_field("window_fill", 32'(want.fill), 32'(m_axis_tdata[100:96]));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				stats_q.push_back(measure_frame(s_axis_tdata[STAMP_W-1:0]));
			pending <= stats_q.size();
		end
	end

endmodule

// File: tb/frame_rate_meter_top_tb.sv
// Testbench for the frame rate meter. The top only produces stimulus and
// gives the verdict; the checker beside the block watches every channel,
// keeps its own model of the meter and compares each result beat.
module frame_rate_meter_top_tb;
	import frm_pkg::*;

	// Item at which the receiver stops taking results for a long stretch.
	localparam int STALL_AT    = 200;
	localparam int LONG_STALL  = 3000;
	localparam int PHASE_ITEMS = 400;
	localparam int END_SETTLE  = 300;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [FREQ_W-1:0]       cfg_data = '0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]   m_axis_tdata;
	logic [OUT_USER_W-1:0]   m_axis_tuser;

	int                      errors;
	int                      pending;
	int                      items_sent = 0;
	// When set, the sender offers stamps back to back with no gaps.
	logic                    steady = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	frame_rate_meter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	frame_rate_meter_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.errors        (errors),
		.pending       (pending)
	);

	// Most idle gaps are absent or short; now and then one is long enough to
	// span most of a frame computation in the back end.
	function automatic int unsigned idle_len();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 60)
			return 0;
		if (pick < 92)
			return $urandom_range(3, 1);
		return $urandom_range(200, 20);
	endfunction

	// Picks the next stamp. Most frames advance by a plausible frame period
	// for the current counter frequency with some jitter. The rest are
	// repeated stamps, tiny steps and stamps drawn from the whole 48-bit range,
	// which cover counter wrap, saturation and every stamp bit.
	function automatic logic [STAMP_W-1:0] next_stamp(logic [STAMP_W-1:0] prev,
			logic [FREQ_W-1:0] freq);
		int unsigned pick;
		logic [63:0] step;
		logic [63:0] raw;
		pick = $urandom_range(99);
		if (pick < 5) begin
			step = '0;
		end else if (pick < 15) begin
			step = 64'($urandom_range(16));
		end else if (pick < 25) begin
			raw = {$urandom, $urandom};
			return raw[STAMP_W-1:0];
		end else begin
			step = 64'(freq) / 64'($urandom_range(2000, 1)) + 64'($urandom_range(255));
		end
		return prev + step[STAMP_W-1:0];
	endfunction

	// One stamp beat. tvalid stays high between back-to-back beats and is only
	// lowered when a gap comes before the next one.
	task automatic send_stamp(input logic [STAMP_W-1:0] stamp);
		int unsigned gap;
		gap = steady ? 0 : idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_DATA_W'(stamp);
		do
			@(posedge clk);
		while (!s_axis_tready);
		items_sent++;
	endtask

	// Stops offering stamps and waits until every expected result has come
	// back, then waits for the number of extra cycles given.
	task automatic settle(input int unsigned extra);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// Writes the counter frequency. Only called while the block is idle.
	task automatic write_freq(input logic [FREQ_W-1:0] freq);
		cfg_valid <= 1'b1;
		cfg_data <= freq;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Result side: bursts of tready high, short or long, separated by random
	// stalls. Once, the receiver holds off for a long stretch while the sender
	// keeps offering stamps, so the queue fills and the input stalls.
	initial begin : result_sink
		int unsigned burst;
		int unsigned hold;
		logic        stall_done;
		stall_done = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!stall_done && items_sent >= STALL_AT) begin
				stall_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				burst = ($urandom_range(4) == 0) ? $urandom_range(1500, 300) :
					$urandom_range(8, 1);
				repeat (burst) @(posedge clk);
				hold = idle_len();
				if (hold > 0) begin
					m_axis_tready <= 1'b0;
					repeat (hold) @(posedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		logic [STAMP_W-1:0] ts;
		logic [FREQ_W-1:0]  freq;
		logic [FREQ_W-1:0]  phase_freq [4];
		phase_freq = '{32'd10_000_000, 32'hFFFF_FFFF, 32'd1, 32'd1_000_000_000};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, first at the reset frequency of 10 MHz. A zero stamp
		// is an ordinary first stamp; repeating it gives a zero delta.
		send_stamp(48'd0);
		send_stamp(48'd0);
		// A one-tick delta overflows the rate.
		send_stamp(48'd1);
		// Roughly 60 frames per second.
		send_stamp(48'd166_668);
		// A delta near the largest: the rate truncates to zero, frame time saturates.
		ts = 48'hFFFF_FFFF_FFFF;
		send_stamp(ts);
		// The counter wraps back through zero.
		ts = 48'd5;
		send_stamp(ts);
		settle(8);

		// Highest frequency: a delta of one second gives exactly 1.0 and 1000 ms.
		write_freq(32'hFFFF_FFFF);
		ts = ts + 48'hFFFF_FFFF;
		send_stamp(ts);
		ts = ts + 48'd1;
		send_stamp(ts);
		ts = ts + 48'h8000_0000_0000;
		send_stamp(ts);
		settle(8);

		// Lowest frequency: one tick is one second; large deltas saturate the
		// frame time.
		write_freq(32'd1);
		ts = ts + 48'd1;
		send_stamp(ts);
		send_stamp(ts);
		ts = ts + 48'd65_536;
		send_stamp(ts);
		settle(8);

		// Zero frequency lies outside the register's range but the block still
		// defines it: rate and frame time read zero unless the delta is zero.
		write_freq('0);
		ts = ts + 48'd100;
		send_stamp(ts);
		send_stamp(ts);
		settle(8);

		// Random phases, each at its own frequency; the last one is random.
		// Each runs far past the window depth so the oldest rates roll out.
		for (int phase = 0; phase < 5; phase++) begin
			if (phase < 4) begin
				freq = phase_freq[phase];
			end else begin
				do
					freq = $urandom;
				while (freq == '0);
			end
			write_freq(freq);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 50 == 0)
					steady <= ($urandom_range(3) == 0);
				ts = next_stamp(ts, freq);
				send_stamp(ts);
			end
			settle((phase == 4) ? END_SETTLE : 8);
		end

		if (errors == 0) begin
			$display("** frame_rate_meter_top: PASSED **");
		end else begin
			$display("** frame_rate_meter_top: FAILED **");
		end
		$finish;
	end

	// Far beyond the slowest correct run: every stamp through the full
	// computation in the back end plus the longest sender gap and receiver stall.
	initial begin : watchdog
		#50_000_000;
		$display("** frame_rate_meter_top: FAILED **");
		$finish;
	end

endmodule

// File: sim.f
rtl/frm_pkg.sv
rtl/frm_div.sv
rtl/frm_front.sv
rtl/frm_queue.sv
rtl/frm_back.sv
rtl/frame_rate_meter_top.sv
tb/frame_rate_meter_checker.sv
tb/frame_rate_meter_top_tb.sv
